### sv/tch_pkg.sv
`default_nettype none
package tch_pkg;

	localparam int ANGLE_ITERATIONS = 16;
	localparam int ATAN_ENTRIES     = 24;
	localparam int ITERS = (ANGLE_ITERATIONS < ATAN_ENTRIES) ? ANGLE_ITERATIONS : ATAN_ENTRIES;

	// CORDIC datapath width: |x|,|y| < 2^48 plus gain headroom and sign
	localparam int CW = 51;
	// angle accumulator width, units 2^-24 rad
	localparam int AW = 28;
	localparam int NORM_BIT = 46;

	localparam logic signed [AW-1:0] PI_Q24 = AW'(52707179);
	localparam logic signed [17:0] PI_Q13 = 18'sd25736;
	localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
	localparam logic signed [17:0] HEADING_LIMIT = 18'sd25805;

	function automatic logic signed [AW-1:0] atan_q24(input int i);
		logic signed [AW-1:0] r;
		unique case (i)
			0: r = AW'(13176795);
			1: r = AW'(7778716);
			2: r = AW'(4110060);
			3: r = AW'(2086331);
			4: r = AW'(1047214);
			5: r = AW'(524117);
			6: r = AW'(262123);
			7: r = AW'(131069);
			default: r = AW'(65536) >>> (i - 8);
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic signed [15:0] mag_x;
		logic signed [15:0] mag_y;
		logic signed [15:0] mag_z;
		logic signed [15:0] cos_row_x;
		logic signed [15:0] cos_row_y;
		logic signed [15:0] cos_row_z;
	} tch_in_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] z;
	} cordic_t;

endpackage
`default_nettype wire

### sv/tch_if.sv
`default_nettype none
interface tch_in_if;
	import tch_pkg::*;
	logic    valid;
	logic    ready;
	tch_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tch_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] heading;
	modport source (output valid, output heading, input ready);
	modport sink (input valid, input heading, output ready);
endinterface

interface tch_cfg_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/tilt_compensated_heading_core.sv
`default_nettype none
// Tilt-compensated compass heading.
// in_ch: one magnetometer vector plus the third attitude-matrix row per item.
// out_ch: one heading per item, units 2^-13 rad, in input order.
// cfg_ch: writes the declination register (units 2^-13 rad); write it idle.
// Throughput: one item per cycle while out_ch is not stalled. Pipeline stages:
// three product/sum stages, pre-rotation/leading bit, normalize, one stage
// per CORDIC iteration, rounding/clamp, declination/wrap into the output
// register.
// The whole pipeline moves as one when the output register is free or is
// being emptied; a stall on out_ch freezes every stage, nothing is lost.
// Normalization of the CORDIC operands is a leading-bit count over 48 bits
// in its own stage, then a barrel shift in the next.
// Reset clears all valid bits and the declination to zero; cfg_ch is always
// ready.
module tilt_compensated_heading_core
	import tch_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	tch_in_if.sink    in_ch,
	tch_out_if.source out_ch,
	tch_cfg_if.sink   cfg_ch
);

	localparam int NV = 7 + ITERS;

	logic signed [15:0] decl_q;
	logic [NV-1:0] v_q;
	logic en;

	assign en = !v_q[NV-1] || out_ch.ready;
	assign in_ch.ready = en;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = v_q[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= '0;
			v_q <= '0;
		end else begin
			if (cfg_ch.valid) decl_q <= cfg_ch.data;
			if (en) v_q <= {v_q[NV-2:0], in_ch.valid};
		end
	end

	// stage 1: first products
	logic signed [31:0] cxx_s1, mycz_s1, mzcy_s1, mycy_s1, mzcz_s1;
	logic signed [15:0] mx_s1, cx_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			cxx_s1 <= in_ch.data.cos_row_x * in_ch.data.cos_row_x;
			mycz_s1 <= in_ch.data.mag_y * in_ch.data.cos_row_z;
			mzcy_s1 <= in_ch.data.mag_z * in_ch.data.cos_row_y;
			mycy_s1 <= in_ch.data.mag_y * in_ch.data.cos_row_y;
			mzcz_s1 <= in_ch.data.mag_z * in_ch.data.cos_row_z;
			mx_s1 <= in_ch.data.mag_x;
			cx_s1 <= in_ch.data.cos_row_x;
		end
	end

	// stage 2: sums
	logic signed [32:0] cps_s2, hy_s2, dot_s2;
	logic signed [15:0] mx_s2, cx_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			cps_s2 <= 33'sh10000000 - 33'(cxx_s1);
			hy_s2 <= 33'(mycz_s1) - 33'(mzcy_s1);
			dot_s2 <= 33'(mycy_s1) + 33'(mzcz_s1);
			mx_s2 <= mx_s1;
			cx_s2 <= cx_s1;
		end
	end

	// stage 3: second products, headX
	logic signed [49:0] hx_s3;
	logic signed [48:0] t1, t2;
	logic signed [32:0] hy_s3;
	assign t1 = mx_s2 * cps_s2;
	assign t2 = cx_s2 * dot_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			hx_s3 <= 50'(t1) - 50'(t2);
			hy_s3 <= hy_s2;
		end
	end

	// stage 4: CORDIC operands (y = -headY*2^14), half-plane fold, leading bit
	logic signed [CW-1:0] x_c, y_c, x_s4, y_s4;
	logic signed [AW-1:0] z_c, z_s4;
	logic [47:0] m_c;
	logic [5:0] sh_c, sh_s4;
	logic zero_c, zero_s4;
	always_comb begin
		x_c = CW'(hx_s3);
		y_c = -(CW'(hy_s3) <<< 14);
		z_c = '0;
		zero_c = (x_c == 0) && (y_c == 0);
		if (x_c < 0) begin
			z_c = (y_c > 0) ? PI_Q24 : -PI_Q24;
			x_c = -x_c;
			y_c = -y_c;
		end
		m_c = (x_c > ((y_c < 0) ? -y_c : y_c)) ? x_c[47:0] :
			((y_c < 0) ? 48'(-y_c) : y_c[47:0]);
		sh_c = '0;
		for (int b = 0; b <= NORM_BIT; b++) begin
			if (m_c[b]) sh_c = 6'(NORM_BIT - b);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_s4 <= x_c;
			y_s4 <= y_c;
			z_s4 <= z_c;
			sh_s4 <= m_c[47] ? 6'd0 : sh_c;
			zero_s4 <= zero_c;
		end
	end

	// stage 5: normalize shift
	cordic_t c_s5, c_end;
	always_ff @(posedge clk) begin
		if (en) begin
			c_s5.x <= zero_s4 ? '0 : (x_s4 <<< sh_s4);
			c_s5.y <= zero_s4 ? '0 : (y_s4 <<< sh_s4);
			c_s5.z <= z_s4;
		end
	end

	tch_cordic u_cordic (
		.clk  (clk),
		.en   (en),
		.in_c (c_s5),
		.out_c(c_end)
	);

	// zero field yields angle 0 regardless of rotations
	logic [ITERS:0] zp_q;
	always_ff @(posedge clk) begin
		if (en) zp_q <= {zp_q[ITERS-1:0], zero_s4};
	end

	// round and clamp
	logic signed [AW-1:0] ar;
	logic signed [17:0] h_c, h_r;
	assign ar = (zp_q[ITERS] ? AW'(0) : c_end.z) + AW'(1024);
	assign h_c = 18'(ar >>> 11);
	always_ff @(posedge clk) begin
		if (en) begin
			if (h_c > HEADING_LIMIT) h_r <= HEADING_LIMIT;
			else if (h_c < -HEADING_LIMIT) h_r <= -HEADING_LIMIT;
			else h_r <= h_c;
		end
	end

	// declination and single wrap
	logic signed [17:0] hd;
	logic signed [15:0] out_q;
	assign hd = h_r + 18'(decl_q);
	always_ff @(posedge clk) begin
		if (en) begin
			if (decl_q == 0) out_q <= h_r[15:0];
			else if (hd > PI_Q13) out_q <= 16'(hd - TWO_PI_Q13);
			else if (hd < -PI_Q13) out_q <= 16'(hd + TWO_PI_Q13);
			else out_q <= hd[15:0];
		end
	end
	assign out_ch.heading = out_q;

endmodule
`default_nettype wire

### sv/tch_cordic.sv
`default_nettype none
// Pipelined vectoring CORDIC: one micro-rotation per stage, advancing on en.
module tch_cordic
	import tch_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    en,
	input  wire cordic_t in_c,
	output cordic_t      out_c
);

	cordic_t stg_q [ITERS+1];

	assign stg_q[0] = in_c;
	assign out_c = stg_q[ITERS];

	for (genvar i = 0; i < ITERS; i++) begin : g_it
		cordic_t nxt;
		always_comb begin
			nxt = stg_q[i];
			if (stg_q[i].y < 0) begin
				nxt.x = stg_q[i].x - (stg_q[i].y >>> i);
				nxt.y = stg_q[i].y + (stg_q[i].x >>> i);
				nxt.z = stg_q[i].z - atan_q24(i);
			end else begin
				nxt.x = stg_q[i].x + (stg_q[i].y >>> i);
				nxt.y = stg_q[i].y - (stg_q[i].x >>> i);
				nxt.z = stg_q[i].z + atan_q24(i);
			end
		end
		cordic_t r_q;
		always_ff @(posedge clk) begin
			if (en) r_q <= nxt;
		end
		assign stg_q[i+1] = r_q;
	end

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import tch_pkg::*;

	// Heading predictor and in-order store of expected headings
	class heading_scoreboard;
		int decl;
		logic signed [15:0] heading_q[$];
		int errors;
		int checked;
		longint atan_tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};

		function longint angle_q24(longint ay, longint ax);
			longint y, x, z, m, dx, dy;
			y = ay;
			x = ax;
			z = 0;
			if (x == 0 && y == 0) begin
				return 0;
			end
			// left half plane: pre-rotate by pi, exactly backward gives -pi
			if (x < 0) begin
				z = (y > 0) ? 64'sd52707179 : -64'sd52707179;
				x = -x;
				y = -y;
			end
			m = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
			while (m < (64'sd1 <<< 46)) begin
				m = m * 2;
				x = x * 2;
				y = y * 2;
			end
			for (int i = 0; i < ITERS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y < 0) begin
					x = x - dx;
					y = y + dy;
					z = z - atan_tab[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + atan_tab[i];
				end
			end
			return z;
		endfunction

		function void note_vector(tch_in_t v);
			longint mx, my, mz, cx, cy, cz, hy, hx, ang;
			int h;
			mx = v.mag_x; my = v.mag_y; mz = v.mag_z;
			cx = v.cos_row_x; cy = v.cos_row_y; cz = v.cos_row_z;
			hy = (my * cz - mz * cy) * 16384;
			hx = mx * ((64'sd1 <<< 28) - cx * cx) - cx * (my * cy + mz * cz);
			ang = angle_q24(-hy, hx);
			h = int'((ang + 1024) >>> 11);
			if (h > 25805) h = 25805;
			else if (h < -25805) h = -25805;
			// declination applied and wrapped once only when nonzero
			if (decl != 0) begin
				h = h + decl;
				if (h > 25736) h = h - 51472;
				else if (h < -25736) h = h + 51472;
			end
			heading_q.push_back(16'(h));
		endfunction

		function void check_heading(logic signed [15:0] got);
			logic signed [15:0] want;
			if (heading_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected heading item %0d", got);
				return;
			end
			want = heading_q.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				if (errors <= 10) $display("heading mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit calm;
	heading_scoreboard sb;

	tch_in_if  in_ch();
	tch_out_if out_ch();
	tch_cfg_if cfg_ch();

	tilt_compensated_heading_core uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	initial begin
		sb = new();
	end

	// watch both channels at each edge
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) sb.note_vector(in_ch.data);
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_heading(out_ch.heading);
	end

	// receiver stalls in short bursts
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	task automatic send_vector(tch_in_t v);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= v;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic send_fields(int mx, int my, int mz, int cx, int cy, int cz);
		tch_in_t v;
		v.mag_x = 16'(mx); v.mag_y = 16'(my); v.mag_z = 16'(mz);
		v.cos_row_x = 16'(cx); v.cos_row_y = 16'(cy); v.cos_row_z = 16'(cz);
		send_vector(v);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.heading_q.size() != 0) @(posedge clk);
	endtask

	// declination write, only with the pipeline empty
	task automatic write_declination(int d);
		drain();
		repeat (30) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= 16'(d);
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		sb.decl = int'($signed(16'(d)));
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int rand_cos();
		if ($urandom_range(0, 3) != 0) return $urandom_range(0, 32768) - 16384;
		return int'($signed(16'($urandom)));
	endfunction

	int decl_set[8] = '{0, 25739, -25739, 1, -1, 32767, -32768, 0};

	initial begin
		tch_in_t v;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: level attitude, cardinal fields, zero field, extremes
		send_fields(1000, 0, 0, 0, 0, 16384);
		send_fields(-1000, 0, 0, 0, 0, 16384);
		send_fields(0, 1000, 0, 0, 0, 16384);
		send_fields(0, -1000, 0, 0, 0, 16384);
		send_fields(0, 0, 0, 0, 0, 16384);
		send_fields(0, 0, 500, 0, 0, 0);
		send_fields(-32768, 0, 0, 0, 0, -16384);
		send_fields(-1, 0, 0, 0, 0, 16384);
		send_fields(32767, 32767, 32767, 16384, 16384, 16384);
		send_fields(-32768, -32768, -32768, -16384, -16384, -16384);
		send_fields(32767, -32768, 32767, 32767, -32768, 32767);
		send_fields(-32768, 32767, -32768, -32768, 32767, -32768);
		send_fields(1000, 300, -200, 16384, 0, 0);
		send_fields(-700, -1, 20, 0, 11585, 11585);
		send_fields(-1000, 1, 0, 0, 0, 16384);
		send_fields(-1000, -1, 0, 0, 0, 16384);
		for (int p = 0; p < 8; p++) begin
			calm = (p == 7);
			write_declination(p == 3 ? $urandom_range(0, 51478) - 25739 : decl_set[p]);
			send_fields(-1000, 0, 0, 0, 0, 16384);
			send_fields(1000, 0, 0, 0, 0, 16384);
			send_fields(0, -1000, 0, 0, 0, 16384);
			for (int k = 0; k < 85; k++) begin
				if (p == 2 && k == 40) drain();
				v.mag_x = 16'($urandom); v.mag_y = 16'($urandom); v.mag_z = 16'($urandom);
				if ($urandom_range(0, 7) == 0) v.mag_x = 16'($urandom_range(0, 8) - 4);
				v.cos_row_x = 16'(rand_cos());
				v.cos_row_y = 16'(rand_cos());
				v.cos_row_z = 16'(rand_cos());
				send_vector(v);
			end
		end
		drain();
		repeat (40) @(posedge clk);
		$display("tb: %0d headings checked over 8 declination settings,", sb.checked);
		$display("tb: level, tilted, zero-field and out-of-range vectors with stalls");
		if (sb.errors == 0 && sb.heading_q.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
sv/tch_pkg.sv
sv/tch_if.sv
sv/tch_cordic.sv
sv/tilt_compensated_heading_core.sv
dv/tb.sv
